// File: design/jtn_pkg.sv
// Shared types, state codes and TAP transition functions for the TAP navigator.
package jtn_pkg;

    // TAP state codes
    localparam logic [3:0] ST_TLR        = 4'd0;
    localparam logic [3:0] ST_RTI        = 4'd1;
    localparam logic [3:0] ST_SELECT_DR  = 4'd2;
    localparam logic [3:0] ST_CAPTURE_DR = 4'd3;
    localparam logic [3:0] ST_SHIFT_DR   = 4'd4;
    localparam logic [3:0] ST_EXIT1_DR   = 4'd5;
    localparam logic [3:0] ST_PAUSE_DR   = 4'd6;
    localparam logic [3:0] ST_EXIT2_DR   = 4'd7;
    localparam logic [3:0] ST_UPDATE_DR  = 4'd8;
    localparam logic [3:0] ST_SELECT_IR  = 4'd9;
    localparam logic [3:0] ST_CAPTURE_IR = 4'd10;
    localparam logic [3:0] ST_SHIFT_IR   = 4'd11;
    localparam logic [3:0] ST_EXIT1_IR   = 4'd12;
    localparam logic [3:0] ST_PAUSE_IR   = 4'd13;
    localparam logic [3:0] ST_EXIT2_IR   = 4'd14;
    localparam logic [3:0] ST_UPDATE_IR  = 4'd15;

    // Distance from a DR state code to the matching IR state code
    localparam logic [3:0] IR_OFFSET = 4'd7;

    // Request operation codes
    localparam logic [1:0] OP_GOTO       = 2'd0;
    localparam logic [1:0] OP_RESET      = 2'd1;
    localparam logic [1:0] OP_SHIFT_EXIT = 2'd2;

    localparam int         BITS_PER_REQUEST = 6;
    localparam int         CNT_W            = 3;
    localparam logic [CNT_W-1:0] LAST_STEP  = CNT_W'(BITS_PER_REQUEST - 1);

    typedef struct packed {
        logic [1:0] operation;
        logic [3:0] target_state;
    } t_in_item;

    typedef struct packed {
        logic       tms;
        logic [3:0] state_after;
        logic       last;
    } t_out_item;

    typedef enum logic [1:0] {
        CMD_GOTO,
        CMD_RESET,
        CMD_SHIFT_EXIT
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [3:0] target;
    } t_cmd;

    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] cnt;
    } t_back_status;

    typedef struct packed {
        logic       tms;
        logic [3:0] next;
    } t_step;

    // Next state with TMS held high
    function automatic logic [3:0] tms_high_next(input logic [3:0] s);
        logic [3:0] n;
        unique case (s)
            ST_TLR:        n = ST_TLR;
            ST_RTI:        n = ST_SELECT_DR;
            ST_SELECT_DR:  n = ST_SELECT_IR;
            ST_CAPTURE_DR: n = ST_EXIT1_DR;
            ST_SHIFT_DR:   n = ST_EXIT1_DR;
            ST_EXIT1_DR:   n = ST_UPDATE_DR;
            ST_PAUSE_DR:   n = ST_EXIT2_DR;
            ST_EXIT2_DR:   n = ST_UPDATE_DR;
            ST_UPDATE_DR:  n = ST_SELECT_DR;
            ST_SELECT_IR:  n = ST_TLR;
            ST_CAPTURE_IR: n = ST_EXIT1_IR;
            ST_SHIFT_IR:   n = ST_EXIT1_IR;
            ST_EXIT1_IR:   n = ST_UPDATE_IR;
            ST_PAUSE_IR:   n = ST_EXIT2_IR;
            ST_EXIT2_IR:   n = ST_UPDATE_IR;
            default:       n = ST_SELECT_DR;
        endcase
        return n;
    endfunction

    // One step of the standard shortest path from s toward t
    function automatic t_step step_toward(input logic [3:0] s, input logic [3:0] t);
        t_step      r;
        logic [3:0] o;
        logic [3:0] b;
        o = (s >= ST_CAPTURE_IR) ? IR_OFFSET : 4'd0;
        b = s - o;
        r.tms  = 1'b1;
        r.next = s;
        priority case (s)
            ST_TLR: begin
                r.tms  = (t == ST_TLR);
                r.next = (t == ST_TLR) ? ST_TLR : ST_RTI;
            end
            ST_RTI, ST_UPDATE_DR, ST_UPDATE_IR: begin
                r.tms  = (t != ST_RTI);
                r.next = (t == ST_RTI) ? ST_RTI : ST_SELECT_DR;
            end
            ST_SELECT_DR: begin
                r.tms  = !(t >= ST_CAPTURE_DR && t <= ST_UPDATE_DR);
                r.next = r.tms ? ST_SELECT_IR : ST_CAPTURE_DR;
            end
            ST_SELECT_IR: begin
                r.tms  = !(t >= ST_CAPTURE_IR);
                r.next = r.tms ? ST_TLR : ST_CAPTURE_IR;
            end
            default: begin
                // capture through exit2 of either column, folded onto the DR codes
                priority case (b)
                    ST_CAPTURE_DR, ST_SHIFT_DR: begin
                        r.tms  = (t != ST_SHIFT_DR + o);
                        r.next = r.tms ? ST_EXIT1_DR + o : ST_SHIFT_DR + o;
                    end
                    ST_EXIT1_DR: begin
                        r.tms  = !(t >= ST_SHIFT_DR + o && t <= ST_EXIT2_DR + o);
                        r.next = r.tms ? ST_UPDATE_DR + o : ST_PAUSE_DR + o;
                    end
                    ST_PAUSE_DR: begin
                        r.tms  = (t != ST_PAUSE_DR + o);
                        r.next = r.tms ? ST_EXIT2_DR + o : ST_PAUSE_DR + o;
                    end
                    default: begin
                        r.tms  = !(t >= ST_SHIFT_DR + o && t <= ST_PAUSE_DR + o);
                        r.next = r.tms ? ST_UPDATE_DR + o : ST_SHIFT_DR + o;
                    end
                endcase
            end
        endcase
        return r;
    endfunction

endpackage

// File: design/jtn_front.sv
// Front end: accepts requests, classifies them and queues commands for the walker.
module jtn_front #(
    parameter int P_QUEUE_DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  jtn_pkg::t_in_item i_in_item,
    output logic             o_cmd_valid,
    input  logic             i_cmd_pop,
    output jtn_pkg::t_cmd    o_cmd
);

    localparam int AW = (P_QUEUE_DEPTH > 1) ? $clog2(P_QUEUE_DEPTH) : 1;
    localparam logic [AW-1:0] LAST_PTR = AW'(P_QUEUE_DEPTH - 1);
    localparam logic [AW:0]   DEPTH_CNT = (AW + 1)'(P_QUEUE_DEPTH);

    jtn_pkg::t_cmd r_mem [P_QUEUE_DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [AW:0]   r_count;

    jtn_pkg::t_cmd w_cmd;
    logic          w_keep;
    logic          w_wr;
    logic          w_rd;

    // Classify: unused operation codes are taken and dropped
    always_comb begin
        w_cmd.target = i_in_item.target_state;
        w_keep       = 1'b1;
        unique case (i_in_item.operation)
            jtn_pkg::OP_GOTO:       w_cmd.kind = jtn_pkg::CMD_GOTO;
            jtn_pkg::OP_RESET:      w_cmd.kind = jtn_pkg::CMD_RESET;
            jtn_pkg::OP_SHIFT_EXIT: w_cmd.kind = jtn_pkg::CMD_SHIFT_EXIT;
            default: begin
                w_cmd.kind = jtn_pkg::CMD_GOTO;
                w_keep     = 1'b0;
            end
        endcase
    end

    assign full        = (r_count == DEPTH_CNT);
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_mem[r_rd_ptr];
    assign w_wr        = push && !full && w_keep;
    assign w_rd        = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (!w_wr && w_rd) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: design/jtn_back.sv
// Back end: walks the TAP state machine for each command and drives the result register.
module jtn_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cmd_valid,
    output logic                    o_cmd_pop,
    input  jtn_pkg::t_cmd           i_cmd,
    output logic                    empty,
    input  logic                    pop,
    output jtn_pkg::t_out_item      o_out_item,
    output jtn_pkg::t_back_status   o_status
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state                      r_fsm;
    logic [3:0]                  r_tap;
    jtn_pkg::t_cmd               r_cmd;
    logic [jtn_pkg::CNT_W-1:0]   r_cnt;
    logic                        r_out_valid;
    jtn_pkg::t_out_item          r_out;

    jtn_pkg::t_step     w_step;
    jtn_pkg::t_out_item w_res;
    logic               w_emit;
    logic               w_done;

    assign w_emit    = (r_fsm == S_RUN) && (!r_out_valid || pop);
    assign o_cmd_pop = (r_fsm == S_IDLE) && i_cmd_valid;

    always_comb begin
        w_step = jtn_pkg::step_toward(r_tap, r_cmd.target);
        if (r_cmd.kind == jtn_pkg::CMD_RESET) begin
            w_res.tms         = 1'b1;
            w_res.state_after = jtn_pkg::tms_high_next(r_tap);
            w_res.last        = (r_cnt == jtn_pkg::LAST_STEP);
        end else begin
            w_res.tms         = w_step.tms;
            w_res.state_after = w_step.next;
            w_res.last        = (w_step.next == r_cmd.target);
        end
        w_done = w_res.last || (r_cnt == jtn_pkg::LAST_STEP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= S_IDLE;
            r_tap       <= jtn_pkg::ST_RTI;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a new bit refills the register in the cycle the old one is taken
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_fsm)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                        r_cnt <= '0;
                        if (i_cmd.kind == jtn_pkg::CMD_SHIFT_EXIT) begin
                            r_tap <= (r_tap == jtn_pkg::ST_SHIFT_DR) ?
                                     jtn_pkg::ST_EXIT1_DR : jtn_pkg::ST_EXIT1_IR;
                        end else if (i_cmd.kind == jtn_pkg::CMD_RESET ||
                                     i_cmd.target != r_tap) begin
                            r_fsm <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    if (w_emit) begin
                        r_out       <= w_res;
                        r_tap       <= w_res.state_after;
                        r_cnt       <= r_cnt + 1'b1;
                        if (w_done) begin
                            r_fsm <= S_IDLE;
                        end
                    end
                end
                default: r_fsm <= S_IDLE;
            endcase
        end
    end

    assign empty           = !r_out_valid;
    assign o_out_item      = r_out;
    assign o_status.busy   = (r_fsm == S_RUN);
    assign o_status.cnt    = r_cnt;

endmodule

// File: design/jtag_tap_navigator_top.sv
// Top level of the TAP navigator: request queue, path walker and result register.
//
// Requests (goto, six-ones reset, shift-exit) enter a small command queue of
// P_QUEUE_DEPTH entries; a walker behind it holds the TAP state and, while the
// result register is free or being popped, produces one TMS result per clock
// into that single result register. A goto or reset request is taken from the
// queue while the walker is idle and then walks one TMS bit per step; a shift-exit,
// a goto to the held state, or an unused operation code yields no result.
// The walker emits a bit only when the result register is free or being popped,
// so a stalled consumer holds the walker while the queue keeps taking requests.
module jtag_tap_navigator_top #(
    parameter int P_QUEUE_DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  jtn_pkg::t_in_item   i_in_item,
    output logic                empty,
    input  logic                pop,
    output jtn_pkg::t_out_item  o_out_item
);

    logic                  w_cmd_valid;
    logic                  w_cmd_pop;
    jtn_pkg::t_cmd         w_cmd;
    jtn_pkg::t_back_status w_status;

    jtn_front #(
        .P_QUEUE_DEPTH(P_QUEUE_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_item   (i_in_item),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_pop   (w_cmd_pop),
        .o_cmd       (w_cmd)
    );

    jtn_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_pop   (w_cmd_pop),
        .i_cmd       (w_cmd),
        .empty       (empty),
        .pop         (pop),
        .o_out_item  (o_out_item),
        .o_status    (w_status)
    );

    // walker never runs past six bits for one request
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.busy |-> (w_status.cnt <= jtn_pkg::LAST_STEP))
        else $error("walker step count past request limit");

    // walker takes a command only while idle
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> (w_cmd_valid && !w_status.busy))
        else $error("command taken while walker busy or queue empty");

    // a full queue always offers a command
    a_full_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> w_cmd_valid)
        else $error("queue full without a pending command");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result pending after reset");

endmodule
